>>> rtl/core/tcw_pkg.sv
// Shared constants, codes and types for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

	// Default screen geometry
	localparam int ROWS_DEF = 200;
	localparam int COLS_DEF = 100;

	// One cell in the screen store: character byte over ARGB colour
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 32;
	localparam int CELL_W  = CHAR_W + COLOR_W;

	// Control characters
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// Colour after reset
	localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 32'hFFFF_FFFF;

	// Register file: one 32-bit register at byte address 0
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_DEFAULT_COLOR = 1'b0
	} reg_idx_t;

	// Item function codes
	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_LIT   = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

endpackage

>>> rtl/core/tcw_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read data held until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/text_console_writer.sv
// Character-cell text console writer: screen store, cursor and scroll ring.
// Sequence: a put, literal write or read is accepted in the idle state and its result is
// registered in the done state; an item that scrolls first blanks the new bottom row.
// A clear-screen item sweeps every cell of the store before its result.
// One item at a time: the next item is taken only once the last result is registered.
// After reset the store is cleared by a sweep over every cell; in_stall stays high.
`timescale 1ns / 1ps
module text_console_writer #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tcw_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	// Item channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic [7:0]                     char_code,
	input  logic [31:0]                    char_color,
	input  logic [7:0]                     read_row,
	input  logic [6:0]                     read_col,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     cursor_row_out,
	output logic [6:0]                     cursor_col_out,
	output logic [7:0]                     lines_used,
	output logic [7:0]                     cell_char,
	output logic [31:0]                    cell_color
);

	import tcw_pkg::*;

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = $clog2(COLS);
	localparam int LC_W   = $clog2(ROWS + 1);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = ROWS * (1 << COL_W);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [COLOR_W-1:0] default_color_q;
	logic [ROW_W-1:0]   ring_top_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [LC_W-1:0]    lines_q;
	logic               rd_ok_q;
	logic [ROW_W-1:0]   clr_row_q;
	logic [COL_W-1:0]   clr_col_q;
	logic               clr_all_q;
	logic [COLOR_W-1:0] clr_color_q;
	logic               out_valid_q;
	logic [7:0]         out_row_q;
	logic [6:0]         out_col_q;
	logic [7:0]         out_lines_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [COLOR_W-1:0] out_color_q;

	logic               accept;
	logic               clearing;
	logic               clr_done;
	logic               cfg_wr;
	func_t              func_in;

	logic [ROW_W-1:0]   nx_row;
	logic [COL_W-1:0]   nx_col;
	logic [ROW_W-1:0]   nx_top;
	logic [LC_W-1:0]    nx_lc;
	logic               do_wr;
	logic               do_nl;
	logic               scroll;
	logic [COLOR_W-1:0] wr_color;
	logic [COL_W:0]     tab_col;
	logic               rd_ok;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	// Logical row to physical row through the ring base
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
		input logic [ROW_W-1:0] logical);
		logic [ROW_W:0] sum;
		sum = {1'b0, top} + {1'b0, logical};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	assign func_in  = func_t'(func);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign clearing = (state_q == S_INIT) || (state_q == S_CLEAR);
	assign clr_done = (clr_col_q == COL_LAST) && (!clr_all_q || clr_row_q == ROW_LAST);

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DEFAULT_COLOR) begin
			prdata = default_color_q;
		end
	end

	// Cursor, ring and line count after the offered item
	always_comb begin
		nx_row   = cur_row_q;
		nx_col   = cur_col_q;
		nx_top   = ring_top_q;
		nx_lc    = lines_q;
		do_wr    = 1'b0;
		do_nl    = 1'b0;
		scroll   = 1'b0;
		wr_color = default_color_q;
		tab_col  = ({1'b0, cur_col_q} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
		case (func_in)
			FUNC_PUT: begin
				if (char_code == CH_LF || char_code == CH_CR) begin
					do_nl = 1'b1;
				end else if (char_code == CH_BS) begin
					if (cur_col_q != '0) begin
						nx_col = cur_col_q - COL_W'(1);
					end
				end else if (char_code == CH_TAB) begin
					if (tab_col >= (COL_W+1)'(COLS)) begin
						do_nl = 1'b1;
					end else begin
						nx_col = tab_col[COL_W-1:0];
					end
				end else begin
					do_wr = 1'b1;
				end
			end
			FUNC_LIT: begin
				if (char_code == CH_LF || char_code == CH_CR) begin
					do_nl = 1'b1;
				end else begin
					do_wr    = 1'b1;
					wr_color = char_color;
				end
			end
			default: ;
		endcase
		// wrap at the last column
		if (do_wr) begin
			if (cur_col_q == COL_LAST) begin
				do_nl = 1'b1;
			end else begin
				nx_col = cur_col_q + COL_W'(1);
			end
		end
		// new line, scrolling at the bottom row
		if (do_nl) begin
			nx_col = '0;
			if (cur_row_q == ROW_LAST) begin
				scroll = 1'b1;
				nx_top = (ring_top_q == ROW_LAST) ? '0 : ring_top_q + ROW_W'(1);
			end else begin
				nx_row = cur_row_q + ROW_W'(1);
			end
			if (LC_W'(nx_row) >= lines_q) begin
				nx_lc = LC_W'(nx_row) + LC_W'(1);
			end
		end
	end

	assign rd_ok = ({1'b0, read_row} < 9'(ROWS)) && ({1'b0, read_col} < 8'(COLS));

	// Store port steering: clearing sweep or the item's own access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {phys_row(ring_top_q, cur_row_q), cur_col_q};
		ram_wdata = {char_code, wr_color};
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = {clr_row_q, clr_col_q};
			ram_wdata = {{CHAR_W{1'b0}}, clr_color_q};
		end else if (accept && do_wr) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = accept && (func_in == FUNC_READ);
	assign ram_raddr = {phys_row(ring_top_q, read_row[ROW_W-1:0]), read_col[COL_W-1:0]};

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, architectural state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_INIT;
			default_color_q <= DEFAULT_COLOR_RST;
			ring_top_q      <= '0;
			cur_row_q       <= '0;
			cur_col_q       <= '0;
			lines_q         <= LC_W'(1);
			rd_ok_q         <= 1'b0;
			clr_row_q       <= '0;
			clr_col_q       <= '0;
			clr_all_q       <= 1'b1;
			clr_color_q     <= DEFAULT_COLOR_RST;
			out_valid_q     <= 1'b0;
			out_row_q       <= '0;
			out_col_q       <= '0;
			out_lines_q     <= '0;
			out_char_q      <= '0;
			out_color_q     <= '0;
		end else begin
			if (cfg_wr && paddr[2] == REG_DEFAULT_COLOR) begin
				default_color_q <= pwdata;
			end
			// result taken downstream
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT, S_CLEAR: begin
					if (clr_col_q == COL_LAST) begin
						clr_col_q <= '0;
						clr_row_q <= clr_row_q + ROW_W'(1);
					end else begin
						clr_col_q <= clr_col_q + COL_W'(1);
					end
					if (clr_done) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_ok_q <= (func_in == FUNC_READ) && rd_ok;
						state_q <= S_DONE;
						if (func_in == FUNC_CLEAR) begin
							ring_top_q  <= '0;
							cur_row_q   <= '0;
							cur_col_q   <= '0;
							lines_q     <= LC_W'(1);
							clr_row_q   <= '0;
							clr_col_q   <= '0;
							clr_all_q   <= 1'b1;
							clr_color_q <= default_color_q;
							state_q     <= S_CLEAR;
						end else begin
							ring_top_q <= nx_top;
							cur_row_q  <= nx_row;
							cur_col_q  <= nx_col;
							lines_q    <= nx_lc;
							if (scroll) begin
								// blank the old top row, now the bottom row
								clr_row_q   <= ring_top_q;
								clr_col_q   <= '0;
								clr_all_q   <= 1'b0;
								clr_color_q <= default_color_q;
								state_q     <= S_CLEAR;
							end
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_row_q   <= 8'(cur_row_q);
						out_col_q   <= 7'(cur_col_q);
						out_lines_q <= 8'(lines_q);
						out_char_q  <= rd_ok_q ? ram_rdata[CELL_W-1:COLOR_W] : '0;
						out_color_q <= rd_ok_q ? ram_rdata[COLOR_W-1:0] : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_row_out = out_row_q;
	assign cursor_col_out = out_col_q;
	assign lines_used     = out_lines_q;
	assign cell_char      = out_char_q;
	assign cell_color     = out_color_q;

endmodule

>>> rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps
module tcw_checker #(
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] cursor_row_out,
	input logic [6:0] cursor_col_out,
	input logic [7:0] lines_used
);

	// A pending result is not dropped while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result lost while stalled");

	// One item at a time: the input stalls right after a transfer in
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in progress");

	// The cursor row always lies inside the rows in use
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lines_used != 8'd0 |-> lines_used > cursor_row_out)
		else $error("cursor row beyond line count");

	// The reported cursor column stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_col_out) < COLS)
		else $error("cursor column off screen");

endmodule

bind text_console_writer tcw_checker #(
	.COLS(COLS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cursor_row_out(cursor_row_out),
	.cursor_col_out(cursor_col_out),
	.lines_used    (lines_used)
);

>>> tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: screen store, cursor, scroll and clear.
`timescale 1ns / 1ps
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int NROWS = ROWS_DEF;
	localparam int NCOLS = COLS_DEF;
	localparam int CELLS = NROWS * NCOLS;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int HOLD_CYCLES = 400;

	// One input item and one status result
	typedef struct {
		func_t       func;
		logic [7:0]  ch;
		logic [31:0] color;
		logic [7:0]  row;
		logic [6:0]  col;
	} console_cmd_t;

	typedef struct {
		logic [7:0]  crow;
		logic [6:0]  ccol;
		logic [7:0]  lines;
		logic [7:0]  cchar;
		logic [31:0] ccolor;
	} console_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [7:0]  char_code = '0;
	logic [31:0] char_color = '0;
	logic [7:0]  read_row = '0;
	logic [6:0]  read_col = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  cursor_row_out;
	logic [6:0]  cursor_col_out;
	logic [7:0]  lines_used;
	logic [7:0]  cell_char;
	logic [31:0] cell_color;

	text_console_writer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.char_code      (char_code),
		.char_color     (char_color),
		.read_row       (read_row),
		.read_col       (read_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_row_out (cursor_row_out),
		.cursor_col_out (cursor_col_out),
		.lines_used     (lines_used),
		.cell_char      (cell_char),
		.cell_color     (cell_color)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus and expectation stores
	console_cmd_t    cmd_queue[$];
	console_status_t status_due[$];
	int              tx_idle_pct = 0;
	int              rx_idle_pct = 0;
	logic            hold_req = 1'b0;
	int              fail_cnt = 0;
	int              cycle_cnt = 0;

	// Screen shadow
	logic [7:0]  scr_char [CELLS];
	logic [31:0] scr_color [CELLS];
	int unsigned ring_top;
	int unsigned cur_row;
	int unsigned cur_col;
	int unsigned row_count;
	logic [31:0] plain_color = DEFAULT_COLOR_RST;

	function automatic void blank_row(int unsigned pr);
		for (int c = 0; c < NCOLS; c++) begin
			scr_char[pr * NCOLS + c]  = '0;
			scr_color[pr * NCOLS + c] = plain_color;
		end
	endfunction

	function automatic void blank_screen();
		for (int r = 0; r < NROWS; r++)
			blank_row(r);
		ring_top  = 0;
		cur_row   = 0;
		cur_col   = 0;
		row_count = 1;
	endfunction

	// New line; scroll through the ring at the bottom row
	function automatic void line_feed();
		int unsigned old_top;
		cur_col = 0;
		cur_row++;
		if (cur_row >= NROWS) begin
			old_top  = ring_top;
			ring_top = (ring_top + 1) % NROWS;
			blank_row(old_top);
			cur_row  = NROWS - 1;
		end
		if (cur_row >= row_count)
			row_count = cur_row + 1;
	endfunction

	function automatic void put_cell(logic [7:0] ch, logic [31:0] color);
		int unsigned idx;
		if (cur_col < NCOLS) begin
			idx = ((ring_top + cur_row) % NROWS) * NCOLS + cur_col;
			scr_char[idx]  = ch;
			scr_color[idx] = color;
			cur_col++;
		end
		if (cur_col >= NCOLS)
			line_feed();
	endfunction

	function automatic console_status_t console_step(console_cmd_t cmd);
		console_status_t st;
		int unsigned     idx;
		st.cchar  = '0;
		st.ccolor = '0;
		case (cmd.func)
			FUNC_PUT: begin
				if (cmd.ch == CH_LF || cmd.ch == CH_CR) begin
					line_feed();
				end else if (cmd.ch == CH_BS) begin
					if (cur_col > 0)
						cur_col--;
				end else if (cmd.ch == CH_TAB) begin
					cur_col = (cur_col + 4) & ~32'd3;
					if (cur_col >= NCOLS)
						line_feed();
				end else begin
					put_cell(cmd.ch, plain_color);
				end
			end
			FUNC_LIT: begin
				if (cmd.ch == CH_LF || cmd.ch == CH_CR)
					line_feed();
				else
					put_cell(cmd.ch, cmd.color);
			end
			FUNC_READ: begin
				if (cmd.row < NROWS && cmd.col < NCOLS) begin
					idx       = ((ring_top + cmd.row) % NROWS) * NCOLS + cmd.col;
					st.cchar  = scr_char[idx];
					st.ccolor = scr_color[idx];
				end
			end
			default: blank_screen();
		endcase
		st.crow  = cur_row[7:0];
		st.ccol  = cur_col[6:0];
		st.lines = row_count[7:0];
		return st;
	endfunction

	// Driver: one transfer per accepted edge, payload held while stalled
	console_cmd_t cur_cmd;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				status_due.push_back(console_step(cur_cmd));
			if (!in_valid || !in_stall) begin
				if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_cmd    = cmd_queue.pop_front();
					in_valid   <= 1'b1;
					func       <= cur_cmd.func;
					char_code  <= cur_cmd.ch;
					char_color <= cur_cmd.color;
					read_row   <= cur_cmd.row;
					read_col   <= cur_cmd.col;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// Long receiver hold-off, counted down once on request
	int   hold_left = 0;
	logic hold_taken = 1'b0;
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compare each result transfer, then pick the next stall
	always @(posedge clk) begin
		console_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_cnt++;
			end else begin
				want = status_due.pop_front();
				check_field("cursor_row_out", want.crow, cursor_row_out);
				check_field("cursor_col_out", want.ccol, cursor_col_out);
				check_field("lines_used", want.lines, lines_used);
				check_field("cell_char", want.cchar, cell_char);
				check_field("cell_color", want.ccolor, cell_color);
			end
		end
		if (hold_left != 0)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic console_cmd_t rnd_cmd();
		console_cmd_t c;
		c.func  = func_t'($urandom_range(0, 2));
		c.ch    = 8'($urandom);
		c.color = $urandom;
		c.row   = 8'($urandom);
		c.col   = 7'($urandom);
		return c;
	endfunction

	task automatic push(func_t f, logic [7:0] ch, logic [31:0] color,
			logic [7:0] row, logic [6:0] col);
		console_cmd_t c;
		c.func  = f;
		c.ch    = ch;
		c.color = color;
		c.row   = row;
		c.col   = col;
		cmd_queue.push_back(c);
	endtask

	// Register write over the APB port, issued while the block is idle or in its reset sweep
	task automatic cfg_write(logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(4 * int'(REG_DEFAULT_COLOR));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		plain_color = value;
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk); while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0);
	endtask

	// Random traffic built from text lines, blank-line runs, read bursts, noise and clears
	task automatic add_random(int n);
		int           target;
		int           len;
		console_cmd_t c;
		target = cmd_queue.size() + n;
		while (cmd_queue.size() < target) begin
			case ($urandom_range(0, 99)) inside
				[0:34]: begin
					// text line, sometimes pushed far right with tabs to force a wrap
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 26) : 0;
					repeat (len) push(FUNC_PUT, CH_TAB, $urandom, 8'($urandom), 7'($urandom));
					len = $urandom_range(0, 6);
					repeat (len) begin
						c = rnd_cmd();
						c.func = $urandom_range(0, 1) ? FUNC_LIT : FUNC_PUT;
						case ($urandom_range(0, 9))
							0:       c.ch = CH_BS;
							1:       c.ch = CH_TAB;
							2, 3, 4: c.ch = 8'($urandom);
							default: c.ch = 8'($urandom_range(8'h20, 8'h7E));
						endcase
						cmd_queue.push_back(c);
					end
					c = rnd_cmd();
					c.func = $urandom_range(0, 1) ? FUNC_LIT : FUNC_PUT;
					c.ch   = $urandom_range(0, 1) ? CH_CR : CH_LF;
					cmd_queue.push_back(c);
				end
				[35:59]: begin
					// run of new lines, drives the cursor down and into scrolling
					len = $urandom_range(5, 20);
					repeat (len) begin
						c = rnd_cmd();
						c.func = $urandom_range(0, 1) ? FUNC_LIT : FUNC_PUT;
						c.ch   = $urandom_range(0, 1) ? CH_CR : CH_LF;
						cmd_queue.push_back(c);
					end
				end
				[60:84]: begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						c = rnd_cmd();
						c.func = FUNC_READ;
						case ($urandom_range(0, 99)) inside
							[0:39]:  c.row = 8'($urandom_range(0, 7));
							[40:74]: c.row = 8'($urandom_range(0, NROWS - 1));
							[75:87]: c.row = 8'($urandom_range(NROWS - 8, NROWS - 1));
							default: c.row = 8'($urandom_range(NROWS, 255));
						endcase
						case ($urandom_range(0, 99)) inside
							[0:54]:  c.col = 7'($urandom_range(0, 11));
							[55:84]: c.col = 7'($urandom_range(0, NCOLS - 1));
							[85:92]: c.col = 7'($urandom_range(NCOLS - 4, NCOLS - 1));
							default: c.col = 7'($urandom_range(NCOLS, 127));
						endcase
						cmd_queue.push_back(c);
					end
				end
				[85:97]: cmd_queue.push_back(rnd_cmd());
				default: push(FUNC_CLEAR, 8'($urandom), $urandom, 8'($urandom), 7'($urandom));
			endcase
		end
	endtask

	initial begin
		blank_screen();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: busy sender, slow receiver, cleared cells still in the reset colour
		tx_idle_pct = 13;
		rx_idle_pct = 82;
		cfg_write(32'h0000_0000);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'd0);
		push(FUNC_PUT, 8'h41, 32'h0, 8'd0, 7'd0);
		push(FUNC_PUT, 8'h00, 32'hFFFF_FFFF, 8'd255, 7'd127);
		push(FUNC_PUT, 8'hFF, 32'h0, 8'd0, 7'd0);
		push(FUNC_LIT, CH_BS, 32'h0000_0000, 8'd0, 7'd0);
		push(FUNC_LIT, CH_TAB, 32'hFFFF_FFFF, 8'd0, 7'd0);
		push(FUNC_LIT, 8'hFF, 32'h8000_0001, 8'd0, 7'd0);
		push(FUNC_PUT, CH_BS, 32'h0, 8'd0, 7'd0);
		push(FUNC_PUT, CH_TAB, 32'h0, 8'd0, 7'd0);
		push(FUNC_PUT, CH_LF, 32'h0, 8'd0, 7'd0);
		// backspace at column zero leaves the cursor alone
		push(FUNC_PUT, CH_BS, 32'h0, 8'd0, 7'd0);
		push(FUNC_PUT, CH_CR, 32'h0, 8'd0, 7'd0);
		push(FUNC_LIT, CH_CR, 32'h0, 8'd0, 7'd0);
		push(FUNC_LIT, CH_LF, 32'hFFFF_FFFF, 8'd0, 7'd0);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'd0);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'd4);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'd5);
		push(FUNC_READ, 8'h00, 32'h0, 8'(NROWS - 1), 7'(NCOLS - 1));
		// reads off the screen return an empty cell
		push(FUNC_READ, 8'h00, 32'h0, 8'(NROWS), 7'd0);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'(NCOLS));
		push(FUNC_READ, 8'hFF, 32'hFFFF_FFFF, 8'd255, 7'd127);
		push(FUNC_CLEAR, 8'h00, 32'h0, 8'd0, 7'd0);
		push(FUNC_READ, 8'h00, 32'h0, 8'd0, 7'd0);
		add_random(150);
		drain();

		// Phase two: slow sender, busy receiver, random default colour
		tx_idle_pct = 82;
		rx_idle_pct = 13;
		cfg_write($urandom);
		add_random(150);
		drain();

		// Phase three: no idling, one long receiver hold-off to back the block up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		cfg_write(32'hFFFF_FFFF);
		add_random(150);
		hold_req <= 1'b1;
		drain();

		repeat (2 * NCOLS + 16) @(posedge clk);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
